[hdl/pid_steering_controller_assert.svh]
// ----------------------------------------------------------------------------
// PID steering controller assertion macros
// Shared property forms for the checks at the end of the top-level RTL module.
// ----------------------------------------------------------------------------
`ifndef PID_STEERING_CONTROLLER_ASSERT_SVH
`define PID_STEERING_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSC_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSC_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// PID steering controller package
// Constants and types shared by the serial arithmetic units and the top level.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Multiplier operand width consumed one bit per cycle by each multiply lane.
  localparam int MUL_NB = 18;

  // Quotient bits produced by the serial divider (one per cycle).
  localparam int Q_W = 13;

  // Largest quotient magnitude, so that ten times it still fits 16 bits.
  localparam logic [Q_W-1:0] STEER_SAT = Q_W'(3276);

  // Status of the serial divider seen by the sequencer.
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

[hdl/psc_if.sv]
// ----------------------------------------------------------------------------
// PID steering controller channel interfaces
// Valid/ready channels for control ticks and for vehicle commands.
// ----------------------------------------------------------------------------

// One control tick per transaction.
interface psc_tick_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] target_y;
  logic signed [DATA_WIDTH-1:0] reference_y;
  logic                         path_empty;
  logic                         pid_selected;
  logic                         autonomous;
  logic                         stop_request;
  logic                         blind_rush;

  modport source (
    output valid, target_y, reference_y, path_empty, pid_selected, autonomous,
           stop_request, blind_rush,
    input  ready
  );

  modport sink (
    input  valid, target_y, reference_y, path_empty, pid_selected, autonomous,
           stop_request, blind_rush,
    output ready
  );
endinterface

// One vehicle command result per transaction.
interface psc_cmd_if;
  logic               valid;
  logic               ready;
  logic               command_valid;
  logic signed [15:0] steer_out;
  logic        [15:0] speed_out;

  modport source (
    output valid, command_valid, steer_out, speed_out,
    input  ready
  );

  modport sink (
    input  valid, command_valid, steer_out, speed_out,
    output ready
  );
endinterface

[hdl/psc_mul_lane.sv]
// ----------------------------------------------------------------------------
// PID steering controller serial multiply lane
// Signed shift-and-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module psc_mul_lane #(
  parameter int MW = 18
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [MW-1:0]                   mcand,
  input  logic signed [psc_pkg::MUL_NB-1:0]      mplier,
  output logic signed [MW+psc_pkg::MUL_NB:0]     product,
  output logic                                   done
);
  import psc_pkg::*;

  localparam int CW  = $clog2(MUL_NB);
  localparam int SW  = MW + 2;

  logic signed [MW:0]     hi;
  logic [MUL_NB-1:0]      lo;
  logic [MUL_NB-1:0]      mp;
  logic signed [MW-1:0]   mc;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic                   last;
  logic signed [SW-1:0]   addend;
  logic signed [SW-1:0]   sum;

  // The sign bit of the multiplier carries negative weight, so the last step subtracts.
  always_comb begin
    last   = (cnt == CW'(MUL_NB - 1));
    addend = '0;
    if (mp[0]) begin
      addend = last ? -SW'(mc) : SW'(mc);
    end
    sum = SW'(hi) + addend;
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial product shifts right; the bits that drop out form the low half.
  always_ff @(posedge clk) begin
    if (start) begin
      hi <= '0;
      lo <= '0;
      mp <= mplier;
      mc <= mcand;
    end else if (busy) begin
      hi <= sum[SW-1:1];
      lo <= {sum[0], lo[MUL_NB-1:1]};
      mp <= mp >> 1;
    end
  end

  assign product = $signed({hi, lo});

endmodule

[hdl/psc_div_serial.sv]
// ----------------------------------------------------------------------------
// PID steering controller serial divider
// Restoring division of a magnitude by a fixed divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psc_div_serial #(
  parameter int NUMW    = 38,
  parameter int DIVISOR = 51200
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [NUMW-1:0]              dividend,
  output logic [psc_pkg::Q_W-1:0]      quotient,
  output psc_pkg::div_stat_t           stat
);
  import psc_pkg::*;

  localparam int DVW  = 21;
  localparam int CW   = ((NUMW > DVW + Q_W) ? NUMW : DVW + Q_W) + 1;
  localparam int CNTW = $clog2(Q_W);
  localparam logic [CW-1:0] DLIM = CW'(DIVISOR) << Q_W;

  logic [CW-1:0]   rem;
  logic [CW-1:0]   dsh;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done_r;
  logic            ovf_r;
  logic            ge;

  assign ge = (rem >= dsh);

  // Sequencing of the quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(Q_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // A quotient too large for the field is flagged up front and saturated later.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= CW'(dividend);
      dsh   <= DLIM >> 1;
      ovf_r <= (CW'(dividend) >= DLIM);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[Q_W-2:0], ge};
      dsh      <= dsh >> 1;
    end
  end

  assign stat = '{done: done_r, ovf: ovf_r};

endmodule

[hdl/pid_steering_controller.sv]
// ----------------------------------------------------------------------------
// PID steering controller
// Lateral PID with clamped integrator, mapped into the vehicle steering range.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake     Contents
//  tick      in         valid/ready   target_y, reference_y, mode flags
//  command   out        valid/ready   command_valid, steer_out, speed_out
//  cfg       in         cfg_we        cfg_index, cfg_data (write only)
//
//  A PID tick is dominated by two 18-step serial multiplies (gains, then the
//  range mapping) and a 13-step serial divide. Empty-path and non-PID ticks
//  go from acceptance straight to the finish state.
//  One tick is in flight at a time; a finished command waits in the output
//  register while the next tick is taken, and the sequencer stalls at the end
//  only while that register is still full. Reset is synchronous and restores
//  the register defaults and clears the integrator and the last error.
//
`include "pid_steering_controller_assert.svh"

module pid_steering_controller #(
  parameter int DATA_WIDTH    = 16,
  parameter int OUT_LIMIT_MAX = 2560,
  parameter int OUT_LIMIT_MIN = -2560
) (
  input  logic        clk,
  input  logic        rst,
  psc_tick_if.sink    tick,
  psc_cmd_if.source   command,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import psc_pkg::*;

  // Widths of the datapath.
  localparam int EW  = DATA_WIDTH + 1;
  localparam int SW  = DATA_WIDTH + 2;
  localparam int MW  = (SW > MUL_NB) ? SW : MUL_NB;
  localparam int PW  = MW + 1 + MUL_NB;
  localparam int FW  = PW - 8;
  localparam int AW  = FW + 1;
  localparam int SFW = AW + 1;
  localparam int NW  = PW + 1;

  // Mapping constants; the output limits enter the mapping inverted.
  localparam int DEN      = OUT_LIMIT_MIN - OUT_LIMIT_MAX;
  localparam bit DEN_ZERO = (DEN == 0);
  localparam bit DIV_NEG  = (DEN < 0);
  localparam int DIV_MAG  = DEN_ZERO ? 10 : ((DEN < 0) ? -DEN * 10 : DEN * 10);
  localparam logic signed [15:0]       OMAX_V = 16'(OUT_LIMIT_MAX);
  localparam logic signed [15:0]       OMIN_V = 16'(OUT_LIMIT_MIN);
  localparam logic signed [MUL_NB-1:0] DEN_V  = MUL_NB'(DEN);

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN_P      = 3'd0;
  localparam logic [2:0] REG_GAIN_I      = 3'd1;
  localparam logic [2:0] REG_GAIN_D      = 3'd2;
  localparam logic [2:0] REG_INTEG_MAX   = 3'd3;
  localparam logic [2:0] REG_INTEG_MIN   = 3'd4;
  localparam logic [2:0] REG_STEER_MIN   = 3'd5;
  localparam logic [2:0] REG_STEER_MAX   = 3'd6;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd7;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MULP  = 10'b0000000010,
    S_INTEG = 10'b0000000100,
    S_SUM   = 10'b0000001000,
    S_MAPST = 10'b0000010000,
    S_MULM  = 10'b0000100000,
    S_NUM   = 10'b0001000000,
    S_DIVST = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;
  logic signed [23:0] integ_max;
  logic signed [23:0] integ_min;
  logic signed [15:0] steer_range_min;
  logic signed [15:0] steer_range_max;
  logic        [15:0] speed_limit;

  // Controller state.
  logic signed [23:0]   integ_acc;
  logic signed [EW-1:0] last_error;

  // Per-tick working registers.
  logic                 emit;
  logic                 stop_r;
  logic                 blind_r;
  logic signed [EW-1:0] err_r;
  logic signed [23:0]   acc_r;
  logic signed [AW-1:0] pd_r;
  logic signed [15:0]   s_r;
  logic signed [NW-1:0] num_r;
  logic                 q_neg;
  logic signed [15:0]   steer_r;

  // Output register.
  logic               cmd_valid;
  logic               cmd_cv;
  logic signed [15:0] cmd_steer;
  logic        [15:0] cmd_speed;
  logic               out_free;

  // Datapath nets.
  logic                     accept;
  logic                     start_pid;
  logic                     start_ab;
  logic signed [EW-1:0]     err_in;
  logic signed [SW-1:0]     esum;
  logic signed [SW-1:0]     ediff;
  logic signed [16:0]       sdiff;
  logic signed [MUL_NB-1:0] s_off;
  logic signed [MW-1:0]     mc_a, mc_b, mc_c;
  logic signed [MUL_NB-1:0] mp_a, mp_b, mp_c;
  logic signed [PW-1:0]     prod_a, prod_b, prod_c;
  logic                     done_a, done_b, done_c;
  logic signed [FW-1:0]     p8, pi8, d8;
  logic signed [AW-1:0]     acc_new;
  logic signed [23:0]       acc_clamp;
  logic signed [SFW-1:0]    s_full;
  logic signed [15:0]       s_clamp;
  logic signed [NW-1:0]     num_full;
  logic [NW-1:0]            num_mag;
  logic [Q_W-1:0]           div_q;
  div_stat_t                div_stat;
  logic [Q_W-1:0]           q_mag;
  logic signed [15:0]       q_s;
  logic signed [15:0]       steer_pid;
  logic signed [16:0]       mid_sum;
  logic signed [16:0]       mid_adj;
  logic signed [15:0]       mid_half;

  assign tick.ready = (state == S_IDLE);
  assign accept     = tick.valid & tick.ready;
  assign start_pid  = accept & ~tick.path_empty & tick.pid_selected;
  assign start_ab   = start_pid | (state == S_MAPST);
  assign out_free   = ~cmd_valid | command.ready;

  // Error terms of the incoming tick.
  assign err_in = EW'(tick.target_y) - EW'(tick.reference_y);
  assign esum   = SW'(err_in) + SW'(last_error);
  assign ediff  = SW'(err_in) - SW'(last_error);

  // Midpoint of the steering range, rounded toward zero.
  assign mid_sum  = 17'(steer_range_min) + 17'(steer_range_max);
  assign mid_adj  = mid_sum + {16'd0, mid_sum[16]};
  assign mid_half = 16'(mid_adj >>> 1);

  // Lane operands: gains times errors first, then the two mapping products.
  assign sdiff = 17'(steer_range_max) - 17'(steer_range_min);
  assign s_off = MUL_NB'(s_r) - MUL_NB'(OMAX_V);

  always_comb begin
    if (state == S_MAPST) begin
      mc_a = MW'(sdiff);
      mp_a = s_off;
      mc_b = MW'(DEN_V);
      mp_b = MUL_NB'(steer_range_min);
    end else begin
      mc_a = MW'(err_in);
      mp_a = MUL_NB'(gain_p);
      mc_b = MW'(esum);
      mp_b = MUL_NB'(gain_i);
    end
    mc_c = MW'(ediff);
    mp_c = MUL_NB'(gain_d);
  end

  psc_mul_lane #(.MW(MW)) u_mul_a (
    .clk(clk), .rst(rst), .start(start_ab),
    .mcand(mc_a), .mplier(mp_a), .product(prod_a), .done(done_a)
  );

  psc_mul_lane #(.MW(MW)) u_mul_b (
    .clk(clk), .rst(rst), .start(start_ab),
    .mcand(mc_b), .mplier(mp_b), .product(prod_b), .done(done_b)
  );

  psc_mul_lane #(.MW(MW)) u_mul_c (
    .clk(clk), .rst(rst), .start(start_pid),
    .mcand(mc_c), .mplier(mp_c), .product(prod_c), .done(done_c)
  );

  // Q16.16 products back to Q8.8, rounding toward minus infinity.
  assign p8  = $signed(prod_a[PW-1:8]);
  assign pi8 = $signed(prod_b[PW-1:8]);
  assign d8  = $signed(prod_c[PW-1:8]);

  // Integrator update, upper bound tested first.
  always_comb begin
    acc_new = AW'(integ_acc) + AW'(pi8);
    priority if (acc_new > AW'(integ_max)) begin
      acc_clamp = integ_max;
    end else if (acc_new < AW'(integ_min)) begin
      acc_clamp = integ_min;
    end else begin
      acc_clamp = acc_new[23:0];
    end
  end

  // PID sum limited to the output range.
  always_comb begin
    s_full = SFW'(pd_r) + SFW'(acc_r);
    priority if (s_full > SFW'(OMAX_V)) begin
      s_clamp = OMAX_V;
    end else if (s_full < SFW'(OMIN_V)) begin
      s_clamp = OMIN_V;
    end else begin
      s_clamp = s_full[15:0];
    end
  end

  // Mapping numerator and its magnitude for the divider.
  assign num_full = NW'(prod_a) + NW'(prod_b);
  assign num_mag  = num_r[NW-1] ? NW'(-num_r) : NW'(num_r);

  psc_div_serial #(.NUMW(NW), .DIVISOR(DIV_MAG)) u_div (
    .clk(clk), .rst(rst), .start(state == S_DIVST),
    .dividend(num_mag), .quotient(div_q), .stat(div_stat)
  );

  // Saturated quotient, signed and scaled by ten.
  always_comb begin
    q_mag     = (div_stat.ovf || (div_q > STEER_SAT)) ? STEER_SAT : div_q;
    q_s       = q_neg ? -16'(q_mag) : 16'(q_mag);
    steer_pid = (q_s <<< 3) + (q_s <<< 1);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p          <= 16'sd256;
      gain_i          <= '0;
      gain_d          <= '0;
      integ_max       <= 24'sd2560;
      integ_min       <= -24'sd2560;
      steer_range_min <= -16'sd500;
      steer_range_max <= 16'sd500;
      speed_limit     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:      gain_p          <= cfg_data[15:0];
        REG_GAIN_I:      gain_i          <= cfg_data[15:0];
        REG_GAIN_D:      gain_d          <= cfg_data[15:0];
        REG_INTEG_MAX:   integ_max       <= cfg_data;
        REG_INTEG_MIN:   integ_min       <= cfg_data;
        REG_STEER_MIN:   steer_range_min <= cfg_data[15:0];
        REG_STEER_MAX:   steer_range_max <= cfg_data[15:0];
        REG_SPEED_LIMIT: speed_limit     <= cfg_data[15:0];
      endcase
    end
  end

  // Sequencer and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      integ_acc  <= '0;
      last_error <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= start_pid ? S_MULP : S_FIN;
          end
        end
        S_MULP: begin
          if (done_a & done_b & done_c) begin
            state <= S_INTEG;
          end
        end
        S_INTEG: state <= S_SUM;
        S_SUM: begin
          integ_acc  <= acc_r;
          last_error <= err_r;
          state      <= S_MAPST;
        end
        S_MAPST: state <= S_MULM;
        S_MULM: begin
          if (done_a & done_b) begin
            state <= S_NUM;
          end
        end
        S_NUM:   state <= S_DIVST;
        S_DIVST: state <= S_DIV;
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Per-tick working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      emit    <= tick.autonomous & (tick.path_empty | tick.pid_selected);
      stop_r  <= tick.stop_request;
      blind_r <= tick.blind_rush;
      err_r   <= err_in;
      steer_r <= mid_half;
    end
    if (state == S_INTEG) begin
      acc_r <= acc_clamp;
      pd_r  <= AW'(p8) + AW'(d8);
    end
    if (state == S_SUM) begin
      s_r <= s_clamp;
    end
    if (state == S_NUM) begin
      num_r <= DEN_ZERO ? NW'(steer_range_min) : num_full;
    end
    if (state == S_DIVST) begin
      q_neg <= num_r[NW-1] ^ DIV_NEG;
    end
    if ((state == S_DIV) && div_stat.done) begin
      steer_r <= steer_pid;
    end
  end

  // Output register: holds a command until the sink takes the transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      cmd_valid <= 1'b1;
    end else if (command.ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      cmd_cv    <= emit;
      cmd_steer <= (emit && !blind_r) ? steer_r : 16'sd0;
      cmd_speed <= (emit && !stop_r) ? speed_limit : 16'd0;
    end
  end

  assign command.valid         = cmd_valid;
  assign command.command_valid = cmd_cv;
  assign command.steer_out     = cmd_steer;
  assign command.speed_out     = cmd_speed;

  // Checks on sequencing and results.
  `PSC_CHECK_NOW(a_idle_cmd_zero, command.valid && !command.command_valid, command.steer_out == 16'sd0 && command.speed_out == 16'd0, "fields not zero without a command")
  `PSC_CHECK_NEXT(a_short_tick, accept && (tick.path_empty || !tick.pid_selected), state == S_FIN, "short tick did not go to finish")
  `PSC_CHECK_NEXT(a_fin_loads, state == S_FIN && out_free, command.valid && state == S_IDLE, "finished command not loaded")
  `PSC_CHECK_NEXT(a_integ_bound, state == S_INTEG && !cfg_we && integ_min <= integ_max, acc_r <= integ_max && acc_r >= integ_min, "integrator outside its bounds")

endmodule
